FILE: rtl/bir_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bilinear image resize block.
// No dependencies; imported by the controller, datapath and top level.
package bir_pkg;

  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int SRC_CFG_W  = 11;
  localparam int DST_CFG_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST  = 11'd640;
  localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST = 11'd480;
  localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST  = 13'd640;
  localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 13'd480;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } bir_reg_t;

  // Which of the four neighbors a frame read or capture refers to.
  typedef enum logic [1:0] {
    NB_P00,
    NB_P10,
    NB_P01,
    NB_P11
  } bir_nb_t;

  typedef enum logic [3:0] {
    ST_DIV_X,
    ST_WAIT_X,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_IDLE,
    ST_LOAD,
    ST_MAP,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_HORZ,
    ST_VERT,
    ST_DONE
  } bir_state_t;

  typedef struct packed {
    logic    cfg_we;
    logic    div_start;
    logic    div_sel_y;
    logic    ratio_x_we;
    logic    ratio_y_we;
    logic    in_cap;
    logic    wr_en;
    logic    map_en;
    logic    addr_en;
    logic    rd_en;
    bir_nb_t rd_sel;
    logic    cap_en;
    bir_nb_t cap_sel;
    logic    horz_en;
    logic    vert_en;
    logic    res_load;
  } bir_cmd_t;

  typedef struct packed {
    logic div_done;
    logic oor_now;
    logic out_free;
  } bir_status_t;

endpackage

FILE: rtl/bir_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by bir_datapath to compute the scaling ratios.
module bir_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             q_bit;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    q_bit = (trial >= {1'b0, den_r});
    if (q_bit) begin
      rem_nxt = DEN_W'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DEN_W-1:0];
    end
    quo_nxt = {quo_r[NUM_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while a division is running");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider reported done while still busy");

endmodule

FILE: rtl/bir_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, ratio divider, frame memory,
// coordinate mapping and bilinear blend. Depends on bir_pkg and bir_div.
module bir_datapath
  import bir_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024,
  parameter int FRAC_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bir_cmd_t              cmd,
  output bir_status_t           status,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COORD_W-1:0]    in_column,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [PIX_W-1:0]      in_pixel_in,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_out_of_range
);

  localparam int XB     = $clog2(MAX_SRC_WIDTH);
  localparam int YB     = $clog2(MAX_SRC_HEIGHT);
  localparam int MB     = (XB > YB) ? XB : YB;
  localparam int XR_W   = XB + FRAC_BITS;
  localparam int YR_W   = YB + FRAC_BITS;
  localparam int DIV_W  = MB + FRAC_BITS;
  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int SX_W   = COORD_W + XR_W;
  localparam int SY_W   = COORD_W + YR_W;
  localparam int SXI_W  = SX_W - FRAC_BITS;
  localparam int SYI_W  = SY_W - FRAC_BITS;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int T_W    = PIX_W + WT_W;
  localparam int V_W    = T_W + WT_W;

  localparam logic [WT_W-1:0]       ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DST_CFG_W-1:0]  MAXW_C = DST_CFG_W'(MAX_SRC_WIDTH);
  localparam logic [DST_CFG_W-1:0]  MAXH_C = DST_CFG_W'(MAX_SRC_HEIGHT);

  // Configuration registers.
  logic [SRC_CFG_W-1:0] sw_cfg_r, sh_cfg_r;
  logic [DST_CFG_W-1:0] tw_cfg_r, th_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_cfg_r <= SRC_WIDTH_RST;
      sh_cfg_r <= SRC_HEIGHT_RST;
      tw_cfg_r <= DST_WIDTH_RST;
      th_cfg_r <= DST_HEIGHT_RST;
    end else if (cmd.cfg_we) begin
      unique case (bir_reg_t'(cfg_index))
        REG_SRC_WIDTH:  sw_cfg_r <= cfg_data[SRC_CFG_W-1:0];
        REG_SRC_HEIGHT: sh_cfg_r <= cfg_data[SRC_CFG_W-1:0];
        REG_DST_WIDTH:  tw_cfg_r <= cfg_data;
        REG_DST_HEIGHT: th_cfg_r <= cfg_data;
      endcase
    end
  end

  // Last valid source column and row, with the size saturated to the store.
  logic [XB-1:0] sw_m1;
  logic [YB-1:0] sh_m1;

  always_comb begin
    if ({2'b00, sw_cfg_r} >= MAXW_C) begin
      sw_m1 = XB'(MAX_SRC_WIDTH - 1);
    end else if (sw_cfg_r == '0) begin
      sw_m1 = '0;
    end else begin
      sw_m1 = XB'(sw_cfg_r - SRC_CFG_W'(1));
    end
    if ({2'b00, sh_cfg_r} >= MAXH_C) begin
      sh_m1 = YB'(MAX_SRC_HEIGHT - 1);
    end else if (sh_cfg_r == '0) begin
      sh_m1 = '0;
    end else begin
      sh_m1 = YB'(sh_cfg_r - SRC_CFG_W'(1));
    end
  end

  // Ratio divider, shared between the two axes.
  logic [DIV_W-1:0]     div_num;
  logic [DST_CFG_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [XR_W-1:0]      xr_r;
  logic [YR_W-1:0]      yr_r;

  always_comb begin
    if (cmd.div_sel_y) begin
      div_num = DIV_W'({sh_m1, {FRAC_BITS{1'b0}}});
      div_den = th_cfg_r - DST_CFG_W'(1);
    end else begin
      div_num = DIV_W'({sw_m1, {FRAC_BITS{1'b0}}});
      div_den = tw_cfg_r - DST_CFG_W'(1);
    end
  end

  bir_div #(
    .NUM_W (DIV_W),
    .DEN_W (DST_CFG_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // A destination size of one (or zero) maps everything onto source index 0.
  always_ff @(posedge clk) begin
    if (cmd.ratio_x_we) begin
      xr_r <= (tw_cfg_r <= DST_CFG_W'(1)) ? '0 : div_quo[XR_W-1:0];
    end
    if (cmd.ratio_y_we) begin
      yr_r <= (th_cfg_r <= DST_CFG_W'(1)) ? '0 : div_quo[YR_W-1:0];
    end
  end

  // Captured request.
  logic [COORD_W-1:0] col_r, row_r;
  logic [PIX_W-1:0]   pix_in_r;

  always_ff @(posedge clk) begin
    if (cmd.in_cap) begin
      col_r    <= in_column;
      row_r    <= in_row;
      pix_in_r <= in_pixel_in;
    end
  end

  logic oor_now;
  assign oor_now = ({1'b0, col_r} >= tw_cfg_r) || ({1'b0, row_r} >= th_cfg_r);

  // Mapping onto the source grid.
  logic [SX_W-1:0] sx_r;
  logic [SY_W-1:0] sy_r;
  logic            oor_r;

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      sx_r  <= SX_W'(col_r) * SX_W'(xr_r);
      sy_r  <= SY_W'(row_r) * SY_W'(yr_r);
      oor_r <= oor_now;
    end
  end

  logic [SXI_W-1:0]     sx_int;
  logic [SYI_W-1:0]     sy_int;
  logic [XB-1:0]        x0, x1;
  logic [YB-1:0]        y0, y1;
  logic [XB-1:0]        x0_r, x1_r;
  logic [YB-1:0]        y0_r, y1_r;
  logic [FRAC_BITS-1:0] dx_r, dy_r;

  always_comb begin
    sx_int = sx_r[SX_W-1:FRAC_BITS];
    sy_int = sy_r[SY_W-1:FRAC_BITS];
    x0 = (sx_int > SXI_W'(sw_m1)) ? sw_m1 : sx_int[XB-1:0];
    y0 = (sy_int > SYI_W'(sh_m1)) ? sh_m1 : sy_int[YB-1:0];
    x1 = (x0 == sw_m1) ? x0 : x0 + XB'(1);
    y1 = (y0 == sh_m1) ? y0 : y0 + YB'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      x0_r <= x0;
      x1_r <= x1;
      y0_r <= y0;
      y1_r <= y1;
      dx_r <= sx_r[FRAC_BITS-1:0];
      dy_r <= sy_r[FRAC_BITS-1:0];
    end
  end

  // Frame memory, single port: a load writes, an in-range sample reads four times.
  logic [XB-1:0]    rd_x;
  logic [YB-1:0]    rd_y;
  logic [AW-1:0]    rd_addr, wr_addr, mem_addr;
  logic             load_ok;
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  always_comb begin
    unique case (cmd.rd_sel)
      NB_P00: begin rd_x = x0_r; rd_y = y0_r; end
      NB_P10: begin rd_x = x1_r; rd_y = y0_r; end
      NB_P01: begin rd_x = x0_r; rd_y = y1_r; end
      NB_P11: begin rd_x = x1_r; rd_y = y1_r; end
    endcase
  end

  assign rd_addr  = AW'(AW'(rd_y) * AW'(MAX_SRC_WIDTH)) + AW'(rd_x);
  assign wr_addr  = AW'(AW'(row_r[YB-1:0]) * AW'(MAX_SRC_WIDTH)) + AW'(col_r[XB-1:0]);
  assign load_ok  = ({1'b0, col_r} < MAXW_C) && ({1'b0, row_r} < MAXH_C);
  assign mem_addr = cmd.wr_en ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && load_ok) begin
      frame_mem[mem_addr] <= pix_in_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= frame_mem[mem_addr];
    end
  end

  // Neighbor capture; the last neighbor is used straight from the read register.
  logic [PIX_W-1:0] p00_r, p10_r, p01_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      unique case (cmd.cap_sel)
        NB_P00: p00_r <= rd_data_r;
        NB_P10: p10_r <= rd_data_r;
        NB_P01: p01_r <= rd_data_r;
        NB_P11: ;
      endcase
    end
  end

  // Horizontal then vertical blend.
  logic [WT_W-1:0]  wx, wy;
  logic [T_W-1:0]   top_r, bot_r;
  logic [V_W-1:0]   value;
  logic [PIX_W-1:0] res_pix_r;

  assign wx = ONE_FX - WT_W'(dx_r);
  assign wy = ONE_FX - WT_W'(dy_r);

  always_ff @(posedge clk) begin
    if (cmd.horz_en) begin
      top_r <= T_W'(p00_r) * T_W'(wx) + T_W'(p10_r) * T_W'(dx_r);
      bot_r <= T_W'(p01_r) * T_W'(wx) + T_W'(rd_data_r) * T_W'(dx_r);
    end
  end

  assign value = V_W'(top_r) * V_W'(wy) + V_W'(bot_r) * V_W'(dy_r);

  always_ff @(posedge clk) begin
    if (cmd.vert_en) begin
      res_pix_r <= value[2*FRAC_BITS +: PIX_W];
    end
  end

  // Output register.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_pix_r <= oor_r ? '0 : res_pix_r;
      out_oor_r <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pix_r;
  assign out_out_of_range = out_oor_r;

  assign status.div_done = div_done;
  assign status.oor_now  = oor_now;
  assign status.out_free = !out_valid_r || !out_stall;

  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("frame memory written and read in the same cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.res_load)
    else $error("pending result overwritten while stalled");

  a_neighbors_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.addr_en |=> (x1_r >= x0_r) && (x1_r <= sw_m1) && (y1_r >= y0_r) && (y1_r <= sh_m1))
    else $error("neighbor index outside the source image");

endmodule

FILE: rtl/bir_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences ratio division, loads and requests.
// Depends on bir_pkg; drives the datapath through bir_cmd_t.
module bir_ctrl
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_stall,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  bir_status_t status,
  output bir_cmd_t    cmd
);

  bir_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DIV_X;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_DIV_X:  state_nxt = ST_WAIT_X;
      ST_WAIT_X: if (status.div_done) state_nxt = ST_DIV_Y;
      ST_DIV_Y:  state_nxt = ST_WAIT_Y;
      ST_WAIT_Y: if (status.div_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        priority if (cfg_valid) begin
          state_nxt = ST_DIV_X;
        end else if (in_valid) begin
          state_nxt = in_kind ? ST_MAP : ST_LOAD;
        end
      end
      ST_LOAD:   state_nxt = ST_IDLE;
      ST_MAP:    state_nxt = status.oor_now ? ST_DONE : ST_ADDR;
      ST_ADDR:   state_nxt = ST_RD0;
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_RD2;
      ST_RD2:    state_nxt = ST_RD3;
      ST_RD3:    state_nxt = ST_HORZ;
      ST_HORZ:   state_nxt = ST_VERT;
      ST_VERT:   state_nxt = ST_DONE;
      ST_DONE:   if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_DIV_X: cmd.div_start = 1'b1;
      ST_WAIT_X: cmd.ratio_x_we = status.div_done;
      ST_DIV_Y: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_y = 1'b1;
      end
      ST_WAIT_Y: begin
        cmd.div_sel_y  = 1'b1;
        cmd.ratio_y_we = status.div_done;
      end
      ST_IDLE: begin
        cfg_ready  = 1'b1;
        in_stall   = cfg_valid;
        cmd.cfg_we = cfg_valid;
        cmd.in_cap = in_valid && !cfg_valid;
      end
      ST_LOAD: cmd.wr_en = 1'b1;
      ST_MAP:  cmd.map_en = 1'b1;
      ST_ADDR: cmd.addr_en = 1'b1;
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = NB_P00;
      end
      ST_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NB_P10;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_P00;
      end
      ST_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NB_P01;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_P10;
      end
      ST_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NB_P11;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NB_P01;
      end
      ST_HORZ: cmd.horz_en = 1'b1;
      ST_VERT: cmd.vert_en = 1'b1;
      ST_DONE: cmd.res_load = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/bilinear_image_resize_core.sv
`timescale 1ns / 1ps
// Top level of the bilinear image resize block.
// Depends on bir_pkg, bir_ctrl, bir_datapath and bir_div.
//
// Usage: the input channel carries two kinds of request. A load (kind 0)
// writes pixel_in into the source frame store at (column, row); loads
// outside the store are dropped and no load produces a result. A sample
// (kind 1) names a destination pixel and produces exactly one result: the
// bilinear blend of the four surrounding source pixels, truncated to
// 8 bits, or zero with out_of_range set when the coordinate lies outside
// the configured destination size. Every source pixel a sample touches must
// have been loaded first.
// Requests are handled one at a time: the input is taken again once a load
// has been written or a sample has put its result in the output register.
// A normal sample steps through map, address, the reads, both blends and
// done; an out-of-range one goes from map straight to done. The mapping
// multiply, four reads through the single-port frame memory and two blend
// stages set the normal sample time. The output register lets the next
// request be taken while a result waits behind a stalled receiver; the block
// only holds off a finished sample when the register is still full.
// Reset, and every configuration write, starts the shared divider that
// computes both scaling ratios, x first and then y; throughout, in_stall is
// high and cfg_ready is low.
module bilinear_image_resize_core
  import bir_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024,
  parameter int FRAC_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [COORD_W-1:0]    in_column,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [PIX_W-1:0]      in_pixel_in,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_pixel_out,
  output logic                  out_out_of_range,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bir_cmd_t    cmd;
  bir_status_t status;

  // The controller only looks at handshakes and datapath status; all
  // payload goes straight into the datapath.
  bir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bir_datapath #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_pixel_in      (in_pixel_in),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pixel_out    (out_pixel_out),
    .out_out_of_range (out_out_of_range)
  );

endmodule
